// File: rtl/core/tds_pkg.sv
// Shared types and constants for the task dependency scheduler.
// No dependencies; used by the controller, the datapath and the top level.
package tds_pkg;

    localparam int TASK_SLOTS          = 256;
    localparam int DEPENDENTS_PER_TASK = 16;

    localparam int TW  = $clog2(TASK_SLOTS);               // handle index bits
    localparam int PW  = $clog2(TASK_SLOTS + 1);           // pointer and count bits
    localparam int UW  = $clog2(DEPENDENTS_PER_TASK + 1);  // dependents count bits
    localparam int LAW = $clog2(TASK_SLOTS * DEPENDENTS_PER_TASK);
    localparam int FW  = 9;                                // in-flight counter bits

    localparam logic [2:0] KIND_APPEND   = 3'd0;
    localparam logic [2:0] KIND_DEP      = 3'd1;
    localparam logic [2:0] KIND_COMPLETE = 3'd2;
    localparam logic [2:0] KIND_POP      = 3'd3;
    localparam logic [2:0] KIND_RESET    = 3'd4;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_DEPS_FULL = 2'd2;
    localparam logic [1:0] ST_SEQ       = 2'd3;

    typedef struct packed {
        logic       capture;
        logic       append;
        logic       clear_cnt;
        logic       consume_dep;
        logic       flight_dec;
        logic       set_pend;
        logic       rd_used;
        logic       used_by_tid;
        logic       link;
        logic       idx_clr;
        logic       rd_list;
        logic       idx_inc;
        logic       rd_rem;
        logic       rem_by_list;
        logic       rem_update;
        logic       count_newly;
        logic       rd_fifo;
        logic       pop_take;
        logic       finish;
        logic [1:0] status;
    } tds_cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       deps_pending;
        logic       table_empty;
        logic       table_full;
        logic       dtask_unknown;
        logic       tid_unknown;
        logic       used_full;
        logic       walk_done;
        logic       fifo_ready;
        logic       out_free;
    } tds_sts_t;

endpackage

// File: rtl/core/tds_datapath.sv
// Datapath: item registers, task tables, dependents lists, ready FIFO and result register.
// Depends on tds_pkg; driven by tds_controller through tds_cmd_t.
module tds_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  tds_pkg::tds_cmd_t   cmd,
    output tds_pkg::tds_sts_t   sts,
    input  logic [2:0]          kind,
    input  logic [7:0]          num_deps,
    input  logic [7:0]          dep_task,
    input  logic [7:0]          task_id,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          handle,
    output logic                ready_valid,
    output logic [7:0]          ready_task,
    output logic [4:0]          newly_ready,
    output logic [8:0]          in_flight,
    output logic [1:0]          status
);

    // Memories
    logic [7:0]                  rem_mem  [tds_pkg::TASK_SLOTS];
    logic [tds_pkg::UW-1:0]      used_mem [tds_pkg::TASK_SLOTS];
    logic [7:0]                  list_mem [tds_pkg::TASK_SLOTS * tds_pkg::DEPENDENTS_PER_TASK];
    logic [7:0]                  fifo_mem [tds_pkg::TASK_SLOTS];

    logic [7:0]                  rem_rdata_reg;
    logic [tds_pkg::UW-1:0]      used_rdata_reg;
    logic [7:0]                  list_rdata_reg;
    logic [7:0]                  fifo_rdata_reg;

    // Captured item
    logic [2:0]                  kind_reg;
    logic [7:0]                  dcount_reg;
    logic [7:0]                  dtask_reg;
    logic [7:0]                  tid_reg;

    // Counters
    logic [tds_pkg::PW-1:0]      total_reg, total_next;
    logic [tds_pkg::PW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [tds_pkg::PW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [tds_pkg::FW-1:0]      flight_reg, flight_next;
    logic [7:0]                  expect_reg, expect_next;
    logic [tds_pkg::UW-1:0]      idx_reg, idx_next;
    logic [tds_pkg::TW-1:0]      rem_addr_reg;

    // Result in progress
    logic [7:0]                  res_handle_reg;
    logic                        res_rvalid_reg;
    logic [7:0]                  res_rtask_reg;
    logic [tds_pkg::UW-1:0]      newly_reg, newly_next;

    // Output register
    logic                        out_valid_reg;
    logic [7:0]                  handle_reg;
    logic                        ready_valid_reg;
    logic [7:0]                  ready_task_reg;
    logic [4:0]                  newly_ready_reg;
    logic [8:0]                  in_flight_reg;
    logic [1:0]                  status_reg;

    logic [tds_pkg::TW-1:0]      total_lo;
    logic [tds_pkg::TW-1:0]      pend_lo;
    logic [tds_pkg::TW-1:0]      dtask_lo;
    logic [tds_pkg::TW-1:0]      tid_lo;
    logic [tds_pkg::TW-1:0]      used_addr;
    logic [tds_pkg::UW-1:0]      walk_len;
    logic [tds_pkg::LAW-1:0]     walk_addr;
    logic [tds_pkg::LAW-1:0]     link_addr;
    logic                        push_en;
    logic [tds_pkg::TW-1:0]      push_val;
    logic                        rem_live;

    assign total_lo  = total_reg[tds_pkg::TW-1:0];
    assign pend_lo   = tds_pkg::TW'(total_reg - tds_pkg::PW'(1));
    assign dtask_lo  = dtask_reg[tds_pkg::TW-1:0];
    assign tid_lo    = tid_reg[tds_pkg::TW-1:0];
    assign used_addr = cmd.used_by_tid ? tid_lo : dtask_lo;
    assign walk_len  = (used_rdata_reg > tds_pkg::UW'(tds_pkg::DEPENDENTS_PER_TASK))
                     ? tds_pkg::UW'(tds_pkg::DEPENDENTS_PER_TASK) : used_rdata_reg;
    assign walk_addr = tds_pkg::LAW'(tid_lo) * tds_pkg::LAW'(tds_pkg::DEPENDENTS_PER_TASK)
                     + tds_pkg::LAW'(idx_reg);
    assign link_addr = tds_pkg::LAW'(dtask_lo) * tds_pkg::LAW'(tds_pkg::DEPENDENTS_PER_TASK)
                     + tds_pkg::LAW'(used_rdata_reg);
    assign rem_live  = (rem_rdata_reg != 8'd0);

    // Pick the handle to push ready, from an append or a release
    always_comb
    begin
        push_en  = 1'b0;
        push_val = rem_addr_reg;
        if (cmd.append && dcount_reg == 8'd0)
        begin
            push_en  = 1'b1;
            push_val = total_lo;
        end
        else if (cmd.rem_update && rem_rdata_reg == 8'd1)
        begin
            push_en = 1'b1;
        end
    end

    // Status towards the controller
    always_comb
    begin
        sts.kind          = kind_reg;
        sts.deps_pending  = (expect_reg != 8'd0);
        sts.table_empty   = (total_reg == '0);
        sts.table_full    = (9'(total_reg) >= 9'(tds_pkg::TASK_SLOTS));
        sts.dtask_unknown = ({1'b0, dtask_reg} >= 9'(total_reg));
        sts.tid_unknown   = ({1'b0, tid_reg} >= 9'(total_reg));
        sts.used_full     = (used_rdata_reg >= tds_pkg::UW'(tds_pkg::DEPENDENTS_PER_TASK));
        sts.walk_done     = (idx_reg >= walk_len);
        sts.fifo_ready    = (rd_ptr_reg < wr_ptr_reg)
                          && (9'(rd_ptr_reg) < 9'(tds_pkg::TASK_SLOTS));
        sts.out_free      = !out_valid_reg || !out_stall;
    end

    // Next values of counters
    always_comb
    begin
        total_next  = total_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        flight_next = flight_reg;
        expect_next = expect_reg;
        idx_next    = idx_reg;
        newly_next  = newly_reg;
        if (cmd.capture)
        begin
            newly_next = '0;
        end
        if (cmd.clear_cnt)
        begin
            total_next  = '0;
            wr_ptr_next = '0;
            rd_ptr_next = '0;
            flight_next = '0;
            expect_next = '0;
        end
        if (cmd.append)
        begin
            total_next = total_reg + tds_pkg::PW'(1);
            if (dcount_reg != 8'd0)
            begin
                expect_next = dcount_reg;
            end
        end
        if (cmd.consume_dep)
        begin
            expect_next = expect_reg - 8'd1;
        end
        if (cmd.flight_dec && flight_reg != '0)
        begin
            flight_next = flight_reg - tds_pkg::FW'(1);
        end
        if (push_en)
        begin
            if (9'(wr_ptr_reg) < 9'(tds_pkg::TASK_SLOTS))
            begin
                wr_ptr_next = wr_ptr_reg + tds_pkg::PW'(1);
            end
            if (flight_reg != {tds_pkg::FW{1'b1}})
            begin
                flight_next = flight_reg + tds_pkg::FW'(1);
            end
            if (cmd.count_newly)
            begin
                newly_next = newly_reg + tds_pkg::UW'(1);
            end
        end
        if (cmd.pop_take)
        begin
            rd_ptr_next = rd_ptr_reg + tds_pkg::PW'(1);
        end
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + tds_pkg::UW'(1);
        end
    end

    // Hold control counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            flight_reg    <= '0;
            expect_reg    <= '0;
            idx_reg       <= '0;
            newly_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            total_reg  <= total_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            flight_reg <= flight_next;
            expect_reg <= expect_next;
            idx_reg    <= idx_next;
            newly_reg  <= newly_next;
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the item, build the result and load the output register
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg       <= kind;
            dcount_reg     <= num_deps;
            dtask_reg      <= dep_task;
            tid_reg        <= task_id;
            res_handle_reg <= 8'd0;
            res_rvalid_reg <= 1'b0;
            res_rtask_reg  <= 8'd0;
        end
        if (cmd.append)
        begin
            res_handle_reg <= 8'(total_lo);
        end
        if (cmd.set_pend)
        begin
            res_handle_reg <= 8'(pend_lo);
        end
        if (cmd.pop_take)
        begin
            res_rvalid_reg <= 1'b1;
            res_rtask_reg  <= fifo_rdata_reg;
        end
        if (cmd.rd_rem)
        begin
            rem_addr_reg <= cmd.rem_by_list ? list_rdata_reg[tds_pkg::TW-1:0] : pend_lo;
        end
        if (cmd.finish)
        begin
            handle_reg      <= res_handle_reg;
            ready_valid_reg <= res_rvalid_reg;
            ready_task_reg  <= res_rtask_reg;
            newly_ready_reg <= 5'(newly_reg);
            in_flight_reg   <= 9'(flight_reg);
            status_reg      <= cmd.status;
        end
    end

    // Remaining-count table
    always_ff @(posedge clk)
    begin
        if (cmd.append)
        begin
            rem_mem[total_lo] <= dcount_reg;
        end
        else if (cmd.rem_update && rem_live)
        begin
            rem_mem[rem_addr_reg] <= rem_rdata_reg - 8'd1;
        end
        if (cmd.rd_rem)
        begin
            rem_rdata_reg <= rem_mem[cmd.rem_by_list ? list_rdata_reg[tds_pkg::TW-1:0]
                                                     : pend_lo];
        end
    end

    // Dependents-used table
    always_ff @(posedge clk)
    begin
        if (cmd.append)
        begin
            used_mem[total_lo] <= '0;
        end
        else if (cmd.link)
        begin
            used_mem[dtask_lo] <= used_rdata_reg + tds_pkg::UW'(1);
        end
        if (cmd.rd_used)
        begin
            used_rdata_reg <= used_mem[used_addr];
        end
    end

    // Dependents lists
    always_ff @(posedge clk)
    begin
        if (cmd.link)
        begin
            list_mem[link_addr] <= 8'(pend_lo);
        end
        if (cmd.rd_list)
        begin
            list_rdata_reg <= list_mem[walk_addr];
        end
    end

    // Ready FIFO
    always_ff @(posedge clk)
    begin
        if (push_en && 9'(wr_ptr_reg) < 9'(tds_pkg::TASK_SLOTS))
        begin
            fifo_mem[wr_ptr_reg[tds_pkg::TW-1:0]] <= 8'(push_val);
        end
        if (cmd.rd_fifo)
        begin
            fifo_rdata_reg <= fifo_mem[rd_ptr_reg[tds_pkg::TW-1:0]];
        end
    end

    assign out_valid   = out_valid_reg;
    assign handle      = handle_reg;
    assign ready_valid = ready_valid_reg;
    assign ready_task  = ready_task_reg;
    assign newly_ready = newly_ready_reg;
    assign in_flight   = in_flight_reg;
    assign status      = status_reg;

endmodule

// File: rtl/core/tds_controller.sv
// Controller: state machine that sequences each item through the datapath.
// Depends on tds_pkg; talks to tds_datapath through tds_cmd_t and tds_sts_t.
module tds_controller
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  tds_pkg::tds_sts_t   sts,
    output tds_pkg::tds_cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_LINK_CHK,
        S_RELEASE,
        S_WALK,
        S_WALK_LIST,
        S_WALK_REM,
        S_POP,
        S_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] st_reg, st_next;

    assign in_stall = (state_reg != S_IDLE);

    // Decode state and status into datapath commands
    always_comb
    begin
        cmd        = '0;
        cmd.status = st_reg;
        state_next = state_reg;
        st_next    = st_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    st_next     = tds_pkg::ST_OK;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                case (sts.kind)
                    tds_pkg::KIND_APPEND:
                    begin
                        if (sts.deps_pending)
                            st_next = tds_pkg::ST_SEQ;
                        else if (sts.table_full)
                            st_next = tds_pkg::ST_FULL;
                        else
                            cmd.append = 1'b1;
                    end
                    tds_pkg::KIND_DEP:
                    begin
                        if (!sts.deps_pending || sts.table_empty)
                        begin
                            st_next = tds_pkg::ST_SEQ;
                        end
                        else
                        begin
                            cmd.consume_dep = 1'b1;
                            cmd.set_pend    = 1'b1;
                            if (sts.dtask_unknown)
                            begin
                                st_next    = tds_pkg::ST_SEQ;
                                cmd.rd_rem = 1'b1;
                                state_next = S_RELEASE;
                            end
                            else
                            begin
                                cmd.rd_used = 1'b1;
                                state_next  = S_LINK_CHK;
                            end
                        end
                    end
                    tds_pkg::KIND_COMPLETE:
                    begin
                        if (sts.tid_unknown)
                        begin
                            st_next = tds_pkg::ST_SEQ;
                        end
                        else
                        begin
                            cmd.flight_dec  = 1'b1;
                            cmd.rd_used     = 1'b1;
                            cmd.used_by_tid = 1'b1;
                            cmd.idx_clr     = 1'b1;
                            state_next      = S_WALK;
                        end
                    end
                    tds_pkg::KIND_POP:
                    begin
                        if (sts.fifo_ready)
                        begin
                            cmd.rd_fifo = 1'b1;
                            state_next  = S_POP;
                        end
                    end
                    tds_pkg::KIND_RESET:
                    begin
                        cmd.clear_cnt = 1'b1;
                    end
                    default:
                    begin
                        st_next = tds_pkg::ST_SEQ;
                    end
                endcase
            end
            S_LINK_CHK:
            begin
                if (sts.used_full)
                begin
                    st_next    = tds_pkg::ST_DEPS_FULL;
                    cmd.rd_rem = 1'b1;
                    state_next = S_RELEASE;
                end
                else
                begin
                    cmd.link   = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_RELEASE:
            begin
                cmd.rem_update = 1'b1;
                state_next     = S_DONE;
            end
            S_WALK:
            begin
                if (sts.walk_done)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd_list = 1'b1;
                    state_next  = S_WALK_LIST;
                end
            end
            S_WALK_LIST:
            begin
                cmd.rd_rem      = 1'b1;
                cmd.rem_by_list = 1'b1;
                cmd.idx_inc     = 1'b1;
                state_next      = S_WALK_REM;
            end
            S_WALK_REM:
            begin
                cmd.rem_update  = 1'b1;
                cmd.count_newly = 1'b1;
                state_next      = S_WALK;
            end
            S_POP:
            begin
                cmd.pop_take = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and the pending status code
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            st_reg    <= tds_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

endmodule

// File: rtl/core/task_dependency_scheduler.sv
// Task dependency scheduler: every item passes capture, execution and the result register;
// a pop also takes the FIFO word, a linked dependency checks the used count, an unknown
// dependency releases its task, a dependency dropped on a full list does both, and a
// completion walks its dependents with one list read, one count read and one count write per
// dependent on the single-port tables. One item at a time; a stalled result holds the item.
// Reset clears handle allocation, FIFO pointers and counters at once; tables are not cleared.
module task_dependency_scheduler
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] kind,
    input  logic [7:0] num_deps,
    input  logic [7:0] dep_task,
    input  logic [7:0] task_id,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] handle,
    output logic       ready_valid,
    output logic [7:0] ready_task,
    output logic [4:0] newly_ready,
    output logic [8:0] in_flight,
    output logic [1:0] status
);

    tds_pkg::tds_cmd_t cmd;
    tds_pkg::tds_sts_t sts;

    // Sequence items
    tds_controller u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Tables, FIFO and result register
    tds_datapath u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .kind        (kind),
        .num_deps    (num_deps),
        .dep_task    (dep_task),
        .task_id     (task_id),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .handle      (handle),
        .ready_valid (ready_valid),
        .ready_task  (ready_task),
        .newly_ready (newly_ready),
        .in_flight   (in_flight),
        .status      (status)
    );

endmodule
